// ===== design/fcgipp_pkg.sv =====
// Shared types and constants for the FastCGI parameter-record parser.
// Used by fcgipp_decode and fastcgi_params_parser; depends on nothing.
package fcgipp_pkg;

    // Parser phase, one-hot
    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_HEAD  = 9'b000000010,
        PH_NLEN  = 9'b000000100,
        PH_NEXT  = 9'b000001000,
        PH_VLEN  = 9'b000010000,
        PH_VEXT  = 9'b000100000,
        PH_NAME  = 9'b001000000,
        PH_VALUE = 9'b010000000,
        PH_DONE  = 9'b100000000
    } t_phase;

    // Result kinds
    localparam logic [2:0] KIND_NAME  = 3'd0;
    localparam logic [2:0] KIND_VALUE = 3'd1;
    localparam logic [2:0] KIND_PAIR  = 3'd2;
    localparam logic [2:0] KIND_OK    = 3'd3;
    localparam logic [2:0] KIND_FAIL  = 3'd4;

    // Header byte offsets (begin-request record, then params record header)
    localparam logic [4:0] OFF_VERSION  = 5'd0;
    localparam logic [4:0] OFF_TYPE     = 5'd17;
    localparam logic [4:0] OFF_CLEN_HI  = 5'd20;
    localparam logic [4:0] OFF_CLEN_LO  = 5'd21;
    localparam logic [4:0] OFF_HDR_LAST = 5'd23;

    localparam logic [7:0]  TYPE_PARAMS   = 8'd4;
    localparam logic [30:0] MAX_FIELD_RST = 31'd65534;

    // One result item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_result;

    // Results caused by one input byte, in delivery order from slot 0
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_res_set;

endpackage

// ===== design/fastcgi_params_parser.sv =====
// Top level of the FastCGI parameter-record parser: input register, result
// buffer and configuration register. Depends on fcgipp_pkg, fcgipp_decode.
//
// Usage:
//   s_axis carries one message byte per transfer; tuser marks the first byte
//   of a message (restarts the parser), tlast the final byte.
//   m_axis delivers result items: tuser is the kind (name byte, value byte,
//   pair complete, success, failure), tdata the name/value byte, tlast marks
//   the last result caused by one input byte.
//   The cfg channel writes the maximum field length; it is always ready and
//   should be written only while no message is in flight.
// Timing:
//   An input byte is held in the input register and decoded into the result
//   buffer, from which its first result is presented on m_axis. One byte per
//   cycle is sustained while m_axis_tready is high and each byte gives at most
//   one result; a byte giving several results holds the 3-entry result buffer
//   until its last result transfers.
//   Bytes with no result pass without waiting.
// Reset: parser idle, buffers empty, maximum field length 65534.
// Stall: while m_axis_tready is low the result buffer holds; a byte with
//   results then waits in the input register and s_axis_tready drops.
module fastcgi_params_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [2:0] out_kind
    output logic        m_axis_tlast,   // run_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic        r_in_last;
    logic [30:0] r_max_len;

    fcgipp_pkg::t_result [2:0] r_res;
    logic [1:0]                r_cnt;

    fcgipp_pkg::t_res_set dec_res;
    logic                 out_xfer;
    logic                 can_load;
    logic                 advance;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= fcgipp_pkg::MAX_FIELD_RST;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Handshake control
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign can_load      = (r_cnt == 2'd0) || (r_cnt == 2'd1 && m_axis_tready);
    assign advance       = r_in_vld && (dec_res.cnt == 2'd0 || can_load);
    assign s_axis_tready = !r_in_vld || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser[0];
            r_in_last  <= s_axis_tlast;
        end
    end

    fcgipp_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_in_byte),
        .i_first   (r_in_first),
        .i_last    (r_in_last),
        .i_max_len (r_max_len),
        .o_results (dec_res)
    );

    // Result buffer: load a whole set, shift out one entry per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (advance && dec_res.cnt != 2'd0) begin
            r_cnt <= dec_res.cnt;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_res.cnt != 2'd0) begin
            r_res <= dec_res.res;
        end else if (out_xfer) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_res[0].data;
    assign m_axis_tuser  = r_res[0].kind;
    assign m_axis_tlast  = (r_cnt == 2'd1);

endmodule

// ===== design/fcgipp_decode.sv =====
// Byte decoder of the FastCGI parameter parser: parser state registers and
// the per-byte next-state and result logic. Depends on fcgipp_pkg.
module fcgipp_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,      // commit this byte's state update
    input  logic [7:0]           i_byte,
    input  logic                 i_first,
    input  logic                 i_last,
    input  logic [30:0]          i_max_len,
    output fcgipp_pkg::t_res_set o_results
);

    fcgipp_pkg::t_phase r_phase, n_phase, ph;
    logic [4:0]  r_hoff, n_hoff, hoff;
    logic [15:0] r_cl, n_cl, cl;
    logic [1:0]  r_ext, n_ext;
    logic [30:0] r_acc, n_acc;
    logic [30:0] r_hnl, n_hnl;
    logic [30:0] r_hvl, n_hvl;
    logic [30:0] r_fl, n_fl;

    logic [30:0] len;
    logic        len_done;
    logic        emit_data;
    logic [2:0]  data_kind;
    logic        emit_pair;
    logic        v_ok;
    logic        v_fail;

    fcgipp_pkg::t_result res_data, res_pair, res_verd;

    // Next state and results for the byte at the input
    always_comb begin
        ph   = i_first ? fcgipp_pkg::PH_HEAD : r_phase;
        hoff = i_first ? 5'd0 : r_hoff;
        cl   = i_first ? 16'd0 : r_cl;

        n_phase = ph;
        n_hoff  = hoff;
        n_cl    = cl;
        n_ext   = r_ext;
        n_acc   = r_acc;
        n_hnl   = r_hnl;
        n_hvl   = r_hvl;
        n_fl    = r_fl;

        len        = 31'd0;
        len_done   = 1'b0;
        emit_data  = 1'b0;
        data_kind  = fcgipp_pkg::KIND_NAME;
        emit_pair  = 1'b0;
        v_ok       = 1'b0;
        v_fail     = 1'b0;

        if (ph == fcgipp_pkg::PH_HEAD) begin
            if (hoff == fcgipp_pkg::OFF_VERSION && i_byte == 8'd0) begin
                v_fail = 1'b1;
            end else if (hoff == fcgipp_pkg::OFF_TYPE && i_byte != fcgipp_pkg::TYPE_PARAMS) begin
                v_fail = 1'b1;
            end else if (hoff == fcgipp_pkg::OFF_CLEN_HI) begin
                n_cl = {i_byte, 8'd0};
            end else if (hoff == fcgipp_pkg::OFF_CLEN_LO) begin
                n_cl = {cl[15:8], i_byte};
            end
            if (!v_fail) begin
                if (hoff >= fcgipp_pkg::OFF_HDR_LAST) begin
                    n_phase = fcgipp_pkg::PH_NLEN;
                    if (n_cl == 16'd0) begin
                        v_ok = 1'b1;
                    end else if (i_last) begin
                        v_fail = 1'b1;
                    end
                end else begin
                    n_hoff = hoff + 5'd1;
                    if (i_last) begin
                        v_fail = 1'b1;
                    end
                end
            end
        end else if (ph != fcgipp_pkg::PH_IDLE && ph != fcgipp_pkg::PH_DONE) begin
            n_cl = cl - 16'd1;
            case (ph)
                fcgipp_pkg::PH_NLEN, fcgipp_pkg::PH_VLEN: begin
                    if (i_byte[7]) begin
                        // long form: three more length bytes follow
                        n_acc   = {24'd0, i_byte[6:0]};
                        n_ext   = 2'd3;
                        n_phase = (ph == fcgipp_pkg::PH_NLEN) ? fcgipp_pkg::PH_NEXT
                                                              : fcgipp_pkg::PH_VEXT;
                    end else begin
                        len      = {23'd0, i_byte};
                        len_done = 1'b1;
                    end
                end
                fcgipp_pkg::PH_NEXT, fcgipp_pkg::PH_VEXT: begin
                    n_acc = {r_acc[22:0], i_byte};
                    n_ext = r_ext - 2'd1;
                    if (n_ext == 2'd0) begin
                        len      = n_acc;
                        len_done = 1'b1;
                    end
                end
                fcgipp_pkg::PH_NAME: begin
                    emit_data = 1'b1;
                    data_kind = fcgipp_pkg::KIND_NAME;
                    n_fl      = r_fl - 31'd1;
                    if (n_fl == 31'd0) begin
                        if (r_hvl == 31'd0) begin
                            emit_pair = 1'b1;
                            n_phase   = fcgipp_pkg::PH_NLEN;
                        end else begin
                            n_fl    = r_hvl;
                            n_phase = fcgipp_pkg::PH_VALUE;
                        end
                    end
                end
                default: begin
                    emit_data = 1'b1;
                    data_kind = fcgipp_pkg::KIND_VALUE;
                    n_fl      = r_fl - 31'd1;
                    if (n_fl == 31'd0) begin
                        emit_pair = 1'b1;
                        n_phase   = fcgipp_pkg::PH_NLEN;
                    end
                end
            endcase

            // a complete length was decoded this byte
            if (len_done) begin
                if (n_phase == fcgipp_pkg::PH_NLEN || n_phase == fcgipp_pkg::PH_NEXT) begin
                    if (len == 31'd0) begin
                        v_ok = 1'b1;
                    end else if (len > i_max_len) begin
                        v_fail = 1'b1;
                    end else begin
                        n_hnl   = len;
                        n_phase = fcgipp_pkg::PH_VLEN;
                    end
                end else if (len > i_max_len) begin
                    v_fail = 1'b1;
                end else begin
                    n_hvl   = len;
                    n_fl    = r_hnl;
                    n_phase = fcgipp_pkg::PH_NAME;
                end
            end

            // content used up, or stream ended inside the content
            if (!v_ok && !v_fail) begin
                if (n_cl == 16'd0) begin
                    if (n_phase == fcgipp_pkg::PH_NLEN) begin
                        v_ok = 1'b1;
                    end else begin
                        v_fail = 1'b1;
                    end
                end else if (i_last) begin
                    v_fail = 1'b1;
                end
            end
        end

        if (v_ok || v_fail) begin
            n_phase = fcgipp_pkg::PH_DONE;
        end
    end

    // Results in order: data byte, pair mark, verdict
    always_comb begin
        res_data.kind = data_kind;
        res_data.data = i_byte;
        res_pair.kind = fcgipp_pkg::KIND_PAIR;
        res_pair.data = 8'd0;
        res_verd.kind = v_fail ? fcgipp_pkg::KIND_FAIL : fcgipp_pkg::KIND_OK;
        res_verd.data = 8'd0;

        o_results.cnt    = {1'b0, emit_data} + {1'b0, emit_pair} + {1'b0, v_ok | v_fail};
        o_results.res[0] = emit_data ? res_data : (emit_pair ? res_pair : res_verd);
        o_results.res[1] = (emit_data && emit_pair) ? res_pair : res_verd;
        o_results.res[2] = res_verd;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fcgipp_pkg::PH_IDLE;
            r_hoff  <= 5'd0;
            r_cl    <= 16'd0;
            r_ext   <= 2'd0;
            r_acc   <= 31'd0;
            r_hnl   <= 31'd0;
            r_hvl   <= 31'd0;
            r_fl    <= 31'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hoff  <= n_hoff;
            r_cl    <= n_cl;
            r_ext   <= n_ext;
            r_acc   <= n_acc;
            r_hnl   <= n_hnl;
            r_hvl   <= n_hvl;
            r_fl    <= n_fl;
        end
    end

endmodule

// ===== tb/tb_fastcgi_params_parser.sv =====
`timescale 1ns / 100ps
// Testbench for fastcgi_params_parser: random FastCGI messages with random idling on both
// streams, checked against a bit-accurate parser model kept in this file.
// Depends on fcgipp_pkg and the parser RTL.
module tb_fastcgi_params_parser;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE_TICKS = 10;    // pipeline drain after the last result
    localparam int PHASE_BYTES  = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_in_byte;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_exp_result;

    typedef enum int {VERD_NONE, VERD_OK, VERD_FAIL} t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data = '0;

    t_in_byte    byte_queue[$];
    t_exp_result awaited_results[$];
    logic [7:0]  msg_bytes[$];
    t_in_byte    next_item;
    int          queued_items = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          recv_stall = 0;
    int          recv_calm = 0;

    // Parser model state
    fcgipp_pkg::t_phase ph = fcgipp_pkg::PH_IDLE;
    logic [4:0]  hdr_off = '0;
    logic [15:0] content_left = '0;
    logic [1:0]  ext_cnt = '0;
    logic [30:0] len_acc = '0;
    logic [30:0] held_nlen = '0;
    logic [30:0] held_vlen = '0;
    logic [30:0] field_left = '0;
    logic [30:0] max_len = fcgipp_pkg::MAX_FIELD_RST;

    fastcgi_params_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Model of the parser: one accepted byte in, its results appended to awaited_results
    task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
        t_exp_result outs[3];
        int          n;
        t_verdict    verdict;
        logic        in_content;
        logic        len_done;
        logic [30:0] len;
        n = 0;
        verdict = VERD_NONE;
        in_content = 1'b0;
        len_done = 1'b0;
        len = '0;
        if (first) begin
            ph = fcgipp_pkg::PH_HEAD;
            hdr_off = '0;
            content_left = '0;
        end
        if (ph == fcgipp_pkg::PH_IDLE || ph == fcgipp_pkg::PH_DONE)
            return;

        if (ph == fcgipp_pkg::PH_HEAD) begin
            if (hdr_off == fcgipp_pkg::OFF_VERSION && b == 8'd0)
                verdict = VERD_FAIL;
            else if (hdr_off == fcgipp_pkg::OFF_TYPE && b != fcgipp_pkg::TYPE_PARAMS)
                verdict = VERD_FAIL;
            else if (hdr_off == fcgipp_pkg::OFF_CLEN_HI)
                content_left = {b, 8'h00};
            else if (hdr_off == fcgipp_pkg::OFF_CLEN_LO)
                content_left[7:0] = b;
            if (verdict == VERD_NONE) begin
                if (hdr_off >= fcgipp_pkg::OFF_HDR_LAST) begin
                    ph = fcgipp_pkg::PH_NLEN;
                    if (content_left == 16'd0)
                        verdict = VERD_OK;
                    else if (last)
                        verdict = VERD_FAIL;
                end else begin
                    hdr_off = hdr_off + 5'd1;
                    if (last)
                        verdict = VERD_FAIL;
                end
            end
        end else begin
            in_content = 1'b1;
            content_left = content_left - 16'd1;
            case (ph)
                fcgipp_pkg::PH_NLEN, fcgipp_pkg::PH_VLEN: begin
                    if (b[7]) begin
                        len_acc = {24'd0, b[6:0]};
                        ext_cnt = 2'd3;
                        ph = (ph == fcgipp_pkg::PH_NLEN) ? fcgipp_pkg::PH_NEXT
                                                         : fcgipp_pkg::PH_VEXT;
                    end else begin
                        len = {23'd0, b};
                        len_done = 1'b1;
                    end
                end
                fcgipp_pkg::PH_NEXT, fcgipp_pkg::PH_VEXT: begin
                    len_acc = {len_acc[22:0], b};
                    ext_cnt = ext_cnt - 2'd1;
                    if (ext_cnt == 2'd0) begin
                        len = len_acc;
                        len_done = 1'b1;
                    end
                end
                fcgipp_pkg::PH_NAME: begin
                    outs[n] = '{fcgipp_pkg::KIND_NAME, b, 1'b0};
                    n++;
                    field_left = field_left - 31'd1;
                    if (field_left == 31'd0) begin
                        if (held_vlen == 31'd0) begin
                            outs[n] = '{fcgipp_pkg::KIND_PAIR, 8'd0, 1'b0};
                            n++;
                            ph = fcgipp_pkg::PH_NLEN;
                        end else begin
                            field_left = held_vlen;
                            ph = fcgipp_pkg::PH_VALUE;
                        end
                    end
                end
                default: begin
                    outs[n] = '{fcgipp_pkg::KIND_VALUE, b, 1'b0};
                    n++;
                    field_left = field_left - 31'd1;
                    if (field_left == 31'd0) begin
                        outs[n] = '{fcgipp_pkg::KIND_PAIR, 8'd0, 1'b0};
                        n++;
                        ph = fcgipp_pkg::PH_NLEN;
                    end
                end
            endcase
            // Decoded length: name length ends the pair list when zero
            if (len_done) begin
                if (ph == fcgipp_pkg::PH_NLEN || ph == fcgipp_pkg::PH_NEXT) begin
                    if (len == 31'd0)
                        verdict = VERD_OK;
                    else if (len > max_len)
                        verdict = VERD_FAIL;
                    else begin
                        held_nlen = len;
                        ph = fcgipp_pkg::PH_VLEN;
                    end
                end else if (len > max_len) begin
                    verdict = VERD_FAIL;
                end else begin
                    held_vlen = len;
                    field_left = held_nlen;
                    ph = fcgipp_pkg::PH_NAME;
                end
            end
        end

        if (verdict == VERD_NONE && in_content) begin
            if (content_left == 16'd0)
                verdict = (ph == fcgipp_pkg::PH_NLEN) ? VERD_OK : VERD_FAIL;
            else if (last)
                verdict = VERD_FAIL;
        end
        if (verdict != VERD_NONE) begin
            outs[n] = '{(verdict == VERD_OK) ? fcgipp_pkg::KIND_OK : fcgipp_pkg::KIND_FAIL,
                        8'd0, 1'b0};
            n++;
            ph = fcgipp_pkg::PH_DONE;
        end
        if (n > 0)
            outs[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_results.insert(awaited_results.size(), outs[i]);
    endtask

    // Idle lengths: mostly none or short, a few long, with calm stretches of no idling
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Input stream driver; prediction happens at each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            s_axis_tlast <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (byte_queue.size() > 0) begin
                    next_item = byte_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_item.data;
                    s_axis_tuser <= next_item.first;
                    s_axis_tlast <= next_item.last;
                    send_gap <= draw_gap(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: kind %0d byte %02h last %0d",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end else begin
                    t_exp_result want;
                    want = awaited_results.pop_front();
                    if (m_axis_tuser != want.kind || m_axis_tdata != want.data ||
                        m_axis_tlast != want.last) begin
                        if (mismatch_count < 10)
                            $display("mismatch: kind %0d/%0d byte %02h/%02h last %0d/%0d (got/want)",
                                     m_axis_tuser, want.kind, m_axis_tdata, want.data,
                                     m_axis_tlast, want.last);
                        mismatch_count++;
                    end
                end
            end
            if (recv_stall > 0) begin
                m_axis_tready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall <= ($urandom_range(0, 3) == 0) ? draw_gap(recv_calm) : 0;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input logic [7:0] b, input logic first, input logic last);
        t_in_byte item;
        item = '{b, first, last};
        byte_queue.insert(byte_queue.size(), item);
        queued_items++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endtask

    function automatic logic [30:0] pick_length(input bit allow_zero);
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return 31'($urandom_range(allow_zero ? 0 : 1, 4));
        if (r == 13)
            return max_len;
        if (r == 14)
            return (max_len == 31'h7fffffff) ? max_len : max_len + 31'd1;
        if (r < 18)
            return 31'($urandom_range(5, 200));
        return 31'($urandom);
    endfunction

    // Short form when it fits (sometimes), else 4-byte form with the high bit set
    task automatic put_length(input logic [30:0] len);
        if (len < 31'd128 && $urandom_range(0, 2) != 0) begin
            put_byte(len[7:0]);
        end else begin
            put_byte({1'b1, len[30:24]});
            put_byte(len[23:16]);
            put_byte(len[15:8]);
            put_byte(len[7:0]);
        end
    endtask

    // One message: begin-request record, params header, pairs, padding; sometimes broken
    task automatic add_message();
        logic [7:0]  kind_byte;
        logic [15:0] clen;
        logic [30:0] nlen;
        logic [30:0] vlen;
        int          csize;
        int          keep;
        int          ending;
        bit          has_last;
        msg_bytes.delete();
        put_byte(($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        repeat (16) put_byte(8'($urandom));
        kind_byte = 8'($urandom);
        if ($urandom_range(0, 14) != 0 || kind_byte == fcgipp_pkg::TYPE_PARAMS)
            kind_byte = fcgipp_pkg::TYPE_PARAMS;
        put_byte(kind_byte);
        repeat (6) put_byte(8'($urandom));

        repeat ($urandom_range(0, 3)) begin
            nlen = pick_length(1'b0);
            vlen = pick_length(1'b1);
            put_length(nlen);
            put_length(vlen);
            repeat ((nlen > 31'd4) ? 31'd4 : nlen) put_byte(8'($urandom));
            repeat ((vlen > 31'd4) ? 31'd4 : vlen) put_byte(8'($urandom));
        end
        // zero name length ends the list; anything after it is ignored
        if ($urandom_range(0, 3) == 0) begin
            put_length(31'd0);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
        end

        csize = msg_bytes.size() - 24;
        case ($urandom_range(0, 9))
            7:       clen = 16'(csize - $urandom_range(0, csize));
            8:       clen = 16'(csize + $urandom_range(1, 4));
            9:       clen = 16'($urandom);
            default: clen = 16'(csize);
        endcase
        msg_bytes[fcgipp_pkg::OFF_CLEN_HI] = clen[15:8];
        msg_bytes[fcgipp_pkg::OFF_CLEN_LO] = clen[7:0];
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom));

        // cut short with an early last, or cut short and restarted by the next message
        keep = msg_bytes.size();
        has_last = 1'b1;
        ending = $urandom_range(0, 9);
        if (ending <= 1) begin
            keep = $urandom_range(1, keep);
            has_last = (ending == 0);
        end
        for (int i = 0; i < keep; i++)
            push_item(msg_bytes[i], i == 0, has_last && i == keep - 1);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) push_item(8'($urandom), 1'b0, 1'($urandom));
    endtask

    task automatic run_phase();
        int start;
        start = queued_items;
        while (queued_items - start < PHASE_BYTES)
            add_message();
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [30:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_len = value;
    endtask

    initial begin
        logic [30:0] settings[4];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes outside any message are dropped
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b1);
        // version zero fails at once
        push_item(8'h00, 1'b1, 1'b0);
        // message abandoned by a restart, then a wrong record type
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0);
        for (int i = 1; i < fcgipp_pkg::OFF_TYPE; i++)
            push_item(8'(i * 37), 1'b0, 1'b0);
        push_item(8'h05, 1'b0, 1'b0);
        // byte after the verdict is ignored
        push_item(8'h80, 1'b0, 1'b1);

        // reset value first, then the extremes and a couple of small limits
        settings[0] = 31'd3;
        settings[1] = 31'd0;
        settings[2] = 31'h7fffffff;
        settings[3] = 31'($urandom_range(1, 300));
        run_phase();
        foreach (settings[i]) begin
            wait_idle();
            write_max_len(settings[i]);
            run_phase();
        end
        wait_idle();

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
